FILE: rtl/cond_number_reg_path_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the condition-number path unit
// Shared clocked property forms; clk and rst are taken from the using module.
// ----------------------------------------------------------------------------
`ifndef COND_NUMBER_REG_PATH_UNIT_MACROS_SVH
`define COND_NUMBER_REG_PATH_UNIT_MACROS_SVH

// same-cycle implication
`define CNRP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CNRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cnrp_pkg.sv
// ----------------------------------------------------------------------------
// cnrp_pkg
// Constants and shared types of the condition-number path unit.
// ----------------------------------------------------------------------------
package cnrp_pkg;

  localparam int MAX_DIM = 16;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int EIG_W   = 32;
  localparam int SUM_W   = 40;
  localparam int Q_W     = 64;
  localparam int PTS_W   = 6;

  localparam logic [Q_W-1:0]   ALL_ONES  = '1;
  localparam logic [Q_W-1:0]   ONE_Q32   = 64'h0000_0001_0000_0000;
  localparam logic [Q_W-1:0]   RECIP_NUM = 64'h0001_0000_0000_0000;
  localparam logic [PTS_W-1:0] MAX_PTS   = 6'd63;

  // request to the shared multiply-divide unit: floor(a*b/c)
  typedef struct packed {
    logic           start;
    logic [Q_W-1:0] a;
    logic [Q_W-1:0] b;
    logic [Q_W-1:0] c;
  } md_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] q;
  } md_rsp_t;

  // one path point from the walker
  typedef struct packed {
    logic           valid;
    logic [Q_W-1:0] cond;
    logic [Q_W-1:0] u;
    logic [Q_W-1:0] v;
    logic           last;
  } res_t;

endpackage

FILE: rtl/cnrp_muldiv.sv
// ----------------------------------------------------------------------------
// cnrp_muldiv
// Iterative floor(a*b/c): four 32x32 partial products, then a restoring
// divide at one quotient bit per cycle. Saturates to all ones.
// ----------------------------------------------------------------------------
`include "cond_number_reg_path_unit_macros.svh"

module cnrp_muldiv import cnrp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  md_req_t req,
  output md_rsp_t rsp
);

  typedef enum logic [3:0] {
    MD_IDLE = 4'b0001,
    MD_MUL  = 4'b0010,
    MD_CHK  = 4'b0100,
    MD_DIV  = 4'b1000
  } md_state_t;

  md_state_t        state;
  logic [Q_W-1:0]   a, b, c;
  logic [2:0]       step;
  logic [63:0]      pp;
  logic [1:0]       psh;
  logic [127:0]     prod;
  logic [Q_W-1:0]   rem, dlo, q;
  logic [5:0]       dcnt;
  logic             done;

  logic [31:0]      ai, bi;
  logic [127:0]     pp_sh;
  logic [Q_W:0]     rem65, diff65;
  logic             ge;

  always_comb begin
    ai = step[1] ? a[63:32] : a[31:0];
    bi = step[0] ? b[63:32] : b[31:0];
    case (psh)
      2'd0:    pp_sh = {64'b0, pp};
      2'd1:    pp_sh = {32'b0, pp, 32'b0};
      default: pp_sh = {pp, 64'b0};
    endcase
    rem65  = {rem, dlo[Q_W-1]};
    diff65 = rem65 - {1'b0, c};
    ge     = (rem65 >= {1'b0, c});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        MD_IDLE: begin
          if (req.start) begin
            a     <= req.a;
            b     <= req.b;
            c     <= req.c;
            prod  <= '0;
            step  <= '0;
            state <= MD_MUL;
          end
        end
        MD_MUL: begin
          if (step != 3'd0) prod <= prod + pp_sh;
          if (step != 3'd4) begin
            pp   <= ai * bi;
            psh  <= {step[1] & step[0], step[1] ^ step[0]};
            step <= step + 3'd1;
          end else begin
            state <= MD_CHK;
          end
        end
        MD_CHK: begin
          if (c == '0 || prod[127:64] >= c) begin
            q     <= ALL_ONES;
            done  <= 1'b1;
            state <= MD_IDLE;
          end else begin
            rem   <= prod[127:64];
            dlo   <= prod[63:0];
            dcnt  <= 6'd63;
            state <= MD_DIV;
          end
        end
        MD_DIV: begin
          rem  <= ge ? diff65[Q_W-1:0] : rem65[Q_W-1:0];
          q    <= {q[Q_W-2:0], ge};
          dlo  <= {dlo[Q_W-2:0], 1'b0};
          dcnt <= dcnt - 6'd1;
          if (dcnt == 6'd0) begin
            done  <= 1'b1;
            state <= MD_IDLE;
          end
        end
        default: state <= MD_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.q    = q;

  `CNRP_ASSERT_IMPLY(a_md_start_idle, req.start, state == MD_IDLE, "start while busy")
  `CNRP_ASSERT_NEXT(a_md_done_pulse, done, !done, "done longer than one cycle")
  `CNRP_ASSERT_IMPLY(a_md_zero_div, done && c == '0, q == ALL_ONES, "zero divisor not saturated")

endmodule

FILE: rtl/cnrp_walk.sv
// ----------------------------------------------------------------------------
// cnrp_walk
// Eigenvalue memory, load accounting and the path-walk sequencer.
// ----------------------------------------------------------------------------
`include "cond_number_reg_path_unit_macros.svh"

module cnrp_walk import cnrp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [EIG_W-1:0] eig_in,
  input  logic             last_in,
  output res_t             res,
  input  logic             res_ready,
  output md_req_t          md_req,
  input  md_rsp_t          md_rsp
);

  typedef enum logic [22:0] {
    ST_LOAD     = 23'h000001,
    ST_MEAN_GO  = 23'h000002,
    ST_MEAN_W   = 23'h000004,
    ST_SRCH_RD  = 23'h000008,
    ST_SRCH_GO  = 23'h000010,
    ST_SRCH_W   = 23'h000020,
    ST_SRCH_END = 23'h000040,
    ST_TAIL     = 23'h000080,
    ST_START_PT = 23'h000100,
    ST_STEP     = 23'h000200,
    ST_HB_GO    = 23'h000400,
    ST_HB_W     = 23'h000800,
    ST_HA_RD    = 23'h001000,
    ST_HA_GO    = 23'h002000,
    ST_HA_W     = 23'h004000,
    ST_T1       = 23'h008000,
    ST_T1_W     = 23'h010000,
    ST_T2       = 23'h020000,
    ST_T2_W     = 23'h040000,
    ST_UPD      = 23'h080000,
    ST_K_W      = 23'h100000,
    ST_K_OUT    = 23'h200000,
    ST_FIN      = 23'h400000
  } walk_state_t;

  walk_state_t      state;
  logic [EIG_W-1:0] mem [MAX_DIM];
  logic [EIG_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_addr;

  logic [CNT_W-1:0] cnt, zcnt, lo, beta;   // lo = alpha + 1
  logic [SUM_W-1:0] sum, head, tail;
  logic [Q_W-1:0]   u, v, h_top, v_left, u_new, v_new, kval;
  logic [EIG_W-1:0] ea, eb;
  logic [PTS_W-1:0] npts;

  logic [EIG_W-1:0] eig_st;
  logic [CNT_W-1:0] lo_m1, rank;
  logic [Q_W-1:0]   dv, du;
  logic             step_ok;

  always_comb begin
    eig_st  = (eig_in == '0) ? EIG_W'(1) : eig_in;
    lo_m1   = lo - CNT_W'(1);
    rank    = cnt - zcnt;
    dv      = (h_top > v) ? h_top - v : '0;
    du      = (u > v_left) ? u - v_left : '0;
    step_ok = (lo != '0) && (beta < rank) && (beta < CNT_W'(MAX_DIM)) && (npts < MAX_PTS);
    rd_addr = (state == ST_STEP) ? beta[IDX_W-1:0] : lo_m1[IDX_W-1:0];
  end

  // eigenvalue memory
  always_ff @(posedge clk) begin
    if (state == ST_LOAD && in_valid && cnt < CNT_W'(MAX_DIM)) begin
      mem[cnt[IDX_W-1:0]] <= eig_st;
    end
    rd_data <= mem[rd_addr];
  end

  assign in_ready = (state == ST_LOAD);

  always_comb begin
    md_req = '0;
    case (state)
      ST_MEAN_GO: begin
        md_req.start = 1'b1;
        md_req.a     = Q_W'(cnt);
        md_req.b     = RECIP_NUM;
        md_req.c     = Q_W'(sum);
      end
      ST_SRCH_GO, ST_HB_GO, ST_HA_GO: begin
        md_req.start = 1'b1;
        md_req.a     = Q_W'(1);
        md_req.b     = RECIP_NUM;
        md_req.c     = Q_W'(rd_data);
      end
      ST_T1: begin
        md_req.start = (head != '0);
        md_req.a     = Q_W'(tail);
        md_req.b     = dv;
        md_req.c     = Q_W'(head);
      end
      ST_T2: begin
        md_req.start = 1'b1;
        md_req.a     = Q_W'(head);
        md_req.b     = du;
        md_req.c     = Q_W'(tail);
      end
      ST_UPD: begin
        md_req.start = 1'b1;
        md_req.a     = v_new;
        md_req.b     = ONE_Q32;
        md_req.c     = u_new;
      end
      default: md_req = '0;
    endcase
  end

  always_comb begin
    res = '0;
    case (state)
      ST_START_PT: begin
        res.valid = 1'b1;
        res.cond  = ONE_Q32;
        res.u     = u;
        res.v     = v;
      end
      ST_K_OUT: begin
        res.valid = 1'b1;
        res.cond  = kval;
        res.u     = u;
        res.v     = v;
      end
      ST_FIN: begin
        res.valid = 1'b1;
        res.cond  = ALL_ONES;
        res.u     = u;
        res.v     = ALL_ONES;
        res.last  = 1'b1;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      cnt   <= '0;
      zcnt  <= '0;
      sum   <= '0;
      lo    <= '0;
      beta  <= '0;
      head  <= '0;
      tail  <= '0;
      u     <= '0;
      v     <= '0;
      npts  <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_valid) begin
            if (cnt < CNT_W'(MAX_DIM)) begin
              cnt <= cnt + CNT_W'(1);
              sum <= sum + SUM_W'(eig_st);
              if (eig_in == '0) zcnt <= zcnt + CNT_W'(1);
            end
            if (last_in) state <= ST_MEAN_GO;
          end
        end
        ST_MEAN_GO: begin
          lo    <= CNT_W'(1);
          head  <= '0;
          state <= ST_MEAN_W;
        end
        ST_MEAN_W: begin
          if (md_rsp.done) begin
            u     <= md_rsp.q;
            v     <= md_rsp.q;
            state <= ST_SRCH_RD;
          end
        end
        ST_SRCH_RD: state <= (lo < cnt) ? ST_SRCH_GO : ST_SRCH_END;
        ST_SRCH_GO: begin
          ea    <= rd_data;
          state <= ST_SRCH_W;
        end
        ST_SRCH_W: begin
          if (md_rsp.done) begin
            if (u > md_rsp.q) begin
              head  <= head + SUM_W'(ea);
              lo    <= lo + CNT_W'(1);
              state <= ST_SRCH_RD;
            end else begin
              state <= ST_SRCH_END;
            end
          end
        end
        ST_SRCH_END: state <= ST_TAIL;
        ST_TAIL: begin
          tail  <= sum - head - SUM_W'(rd_data);
          beta  <= lo;
          state <= ST_START_PT;
        end
        ST_START_PT: begin
          if (res_ready) begin
            npts  <= PTS_W'(1);
            state <= ST_STEP;
          end
        end
        ST_STEP: state <= step_ok ? ST_HB_GO : ST_FIN;
        ST_HB_GO: begin
          eb    <= rd_data;
          state <= ST_HB_W;
        end
        ST_HB_W: begin
          if (md_rsp.done) begin
            h_top <= md_rsp.q;
            state <= ST_HA_RD;
          end
        end
        ST_HA_RD: state <= ST_HA_GO;
        ST_HA_GO: begin
          ea    <= rd_data;
          state <= ST_HA_W;
        end
        ST_HA_W: begin
          if (md_rsp.done) begin
            v_left <= md_rsp.q;
            state  <= ST_T1;
          end
        end
        ST_T1: state <= (head == '0) ? ST_T2 : ST_T1_W;
        ST_T1_W: begin
          if (md_rsp.done) begin
            // horizontal point left of the vertical edge falls back to it
            if (md_rsp.q > u || (u - md_rsp.q) < v_left) begin
              state <= ST_T2;
            end else begin
              u_new <= u - md_rsp.q;
              v_new <= h_top;
              state <= ST_UPD;
            end
          end
        end
        ST_T2: state <= ST_T2_W;
        ST_T2_W: begin
          if (md_rsp.done) begin
            u_new <= v_left;
            v_new <= (md_rsp.q > ~v) ? ALL_ONES : v + md_rsp.q;
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (u_new == v_left) begin
            head <= head - SUM_W'(ea);
            lo   <= lo_m1;
          end
          if (v_new == h_top) begin
            tail <= tail - SUM_W'(eb);
            beta <= beta + CNT_W'(1);
          end
          u     <= u_new;
          v     <= v_new;
          state <= ST_K_W;
        end
        ST_K_W: begin
          if (md_rsp.done) begin
            kval  <= md_rsp.q;
            state <= ST_K_OUT;
          end
        end
        ST_K_OUT: begin
          if (res_ready) begin
            npts  <= npts + PTS_W'(1);
            state <= ST_STEP;
          end
        end
        ST_FIN: begin
          if (res_ready) begin
            cnt   <= '0;
            zcnt  <= '0;
            sum   <= '0;
            lo    <= '0;
            beta  <= '0;
            head  <= '0;
            tail  <= '0;
            u     <= '0;
            v     <= '0;
            npts  <= '0;
            state <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  `CNRP_ASSERT_IMPLY(a_lo_range, 1'b1, lo <= cnt, "lower index past loaded count")
  `CNRP_ASSERT_IMPLY(a_beta_range, 1'b1, beta <= CNT_W'(MAX_DIM) + CNT_W'(1), "upper index out of range")
  `CNRP_ASSERT_NEXT(a_clear_after_set, res.valid && res_ready && res.last, cnt == '0 && state == ST_LOAD, "state not cleared after set")

endmodule

FILE: rtl/cond_number_reg_path_unit.sv
// ----------------------------------------------------------------------------
// cond_number_reg_path_unit
// Forward walk of the condition-number regularization path over one
// eigenvalue set; emits (k, u, v) breakpoints ending with an infinite point.
// ----------------------------------------------------------------------------
// Flow: one item per cycle while loading; after the last item the walk runs one
//   divide for the mean, one per search step and 4 to 5 per path step; a divide
//   runs a start, four partial products, a check and 64 quotient bits, and
//   ends at the check if it saturates. Sets go one at a time, paced by the
//   shared multiply-divide unit, with at most MAX_DIM path steps per set.
// Reset: synchronous, active high; clears the walker and the output valid flag.
//   The eigenvalue memory is not cleared; only entries of the current set
//   are read.
module cond_number_reg_path_unit import cnrp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [31:0]   s_tdata,   // [31:0] eigenvalue
  input  logic          s_tlast,   // last eigenvalue of the set
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [191:0]  m_tdata,   // [63:0] cond_number, [127:64] u_value,
                                   // [191:128] v_value
  output logic          m_tlast    // last_point
);

  md_req_t md_req;
  md_rsp_t md_rsp;
  res_t    res;
  logic    res_ready;

  cnrp_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  cnrp_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .eig_in    (s_tdata),
    .last_in   (s_tlast),
    .res       (res),
    .res_ready (res_ready),
    .md_req    (md_req),
    .md_rsp    (md_rsp)
  );

  // output register: takes a new point when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      m_tdata <= {res.v, res.u, res.cond};
      m_tlast <= res.last;
    end
  end

endmodule

FILE: tb/tb_cond_number_reg_path_unit.sv
// ----------------------------------------------------------------------------
// tb_cond_number_reg_path_unit
// Self-checking bench for the condition-number path unit. Eigenvalue sets
// stream in; a scoreboard class predicts each set's breakpoints when the
// closing item is taken and checks every path point that comes out.
// ----------------------------------------------------------------------------
module tb_cond_number_reg_path_unit;
  import cnrp_pkg::*;

  typedef struct {
    logic [63:0] cond;
    logic [63:0] u;
    logic [63:0] v;
    logic        last;
  } path_point_t;

  // Predicts the path of each set and holds the breakpoints not yet seen.
  class path_scoreboard;
    logic [31:0] eig [MAX_DIM];
    int          loaded;
    int          zeros;
    path_point_t expected_q [$];
    int          errors;
    int          sets;
    int          points;

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    // floor(a*b/c), all ones when the quotient overflows or c is zero
    function logic [63:0] mul_div(logic [63:0] a, logic [63:0] b, logic [63:0] c);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      if (c == 0 || prod[127:64] >= c) return ALL_ONES;
      return 64'(prod / {64'd0, c});
    endfunction

    function logic [63:0] recip(logic [31:0] e);
      if (e == 0) return ALL_ONES;
      return RECIP_NUM / {32'd0, e};
    endfunction

    function void push(logic [63:0] k, logic [63:0] u, logic [63:0] v, logic l);
      path_point_t pt;
      pt.cond = k; pt.u = u; pt.v = v; pt.last = l;
      expected_q.insert(expected_q.size(), pt);
    endfunction

    function void walk_path();
      int          rank;
      int          lo_idx;
      int          hi_idx;
      int          n;
      logic [63:0] total;
      logic [63:0] head;
      logic [63:0] tail;
      logic [63:0] u_cur;
      logic [63:0] v_cur;
      logic [63:0] h_top;
      logic [63:0] v_left;
      logic [63:0] u_nxt;
      logic [63:0] v_nxt;
      logic [63:0] diff;
      logic [63:0] t;
      bit          vert;
      rank = loaded - zeros;
      total = 0;
      for (int i = 0; i < loaded; i++) total += eig[i];
      u_cur = mul_div(loaded, RECIP_NUM, total);
      v_cur = u_cur;
      lo_idx = 0;
      while (lo_idx < loaded - 1 && u_cur > recip(eig[lo_idx])) lo_idx++;
      hi_idx = lo_idx + 1;
      head = 0;
      for (int i = 0; i < lo_idx; i++) head += eig[i];
      tail = 0;
      for (int i = hi_idx; i < loaded; i++) tail += eig[i];
      push(ONE_Q32, u_cur, v_cur, 1'b0);
      n = 1;
      while (lo_idx >= 0 && hi_idx <= rank - 1 && hi_idx < MAX_DIM && n < 63) begin
        h_top  = recip(eig[hi_idx]);
        v_left = recip(eig[lo_idx]);
        u_nxt  = 0;
        v_nxt  = h_top;
        vert   = (head == 0);
        if (!vert) begin
          diff = (h_top > v_cur) ? h_top - v_cur : 64'd0;
          t = mul_div(tail, diff, head);
          // horizontal hit would land left of the vertical edge
          if (t > u_cur || u_cur - t < v_left) vert = 1'b1;
          else u_nxt = u_cur - t;
        end
        if (vert) begin
          diff = (u_cur > v_left) ? u_cur - v_left : 64'd0;
          t = mul_div(head, diff, tail);
          u_nxt = v_left;
          v_nxt = (t > ALL_ONES - v_cur) ? ALL_ONES : v_cur + t;
        end
        if (u_nxt == v_left) begin
          head -= eig[lo_idx];
          lo_idx--;
        end
        if (v_nxt == h_top) begin
          tail -= eig[hi_idx];
          hi_idx++;
        end
        push(mul_div(v_nxt, ONE_Q32, u_nxt), u_nxt, v_nxt, 1'b0);
        n++;
        u_cur = u_nxt;
        v_cur = v_nxt;
      end
      push(ALL_ONES, u_cur, ALL_ONES, 1'b1);
    endfunction

    function void note_input(logic [31:0] e, logic l);
      if (loaded < MAX_DIM) begin
        if (e == 0) begin
          zeros++;
          e = 32'd1;  // rank deficiency: stored as one LSB
        end
        eig[loaded] = e;
        loaded++;
      end
      if (l) begin
        walk_path();
        sets++;
        loaded = 0;
        zeros  = 0;
      end
    endfunction

    function void check_result(logic [191:0] data, logic l);
      path_point_t pt;
      points++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected point k=%h", data[63:0]));
        return;
      end
      pt = expected_q.pop_front();
      if (data[63:0] !== pt.cond)
        report($sformatf("cond_number %h, expected %h", data[63:0], pt.cond));
      if (data[127:64] !== pt.u)
        report($sformatf("u_value %h, expected %h", data[127:64], pt.u));
      if (data[191:128] !== pt.v)
        report($sformatf("v_value %h, expected %h", data[191:128], pt.v));
      if (l !== pt.last)
        report($sformatf("last_point %0b, expected %0b", l, pt.last));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [191:0] m_tdata;
  logic         m_tlast;

  path_scoreboard path_sb = new();
  bit             steady;      // no idling on either side while set
  bit             drained_once;
  int             items_sent;

  cond_number_reg_path_unit DUT (.*);

  always #4 clk = ~clk;

  // output side: random back-pressure, every taken point checked
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) path_sb.check_result(m_tdata, m_tlast);
    m_tready <= steady || ($urandom_range(99) >= 32);
  end

  // Offer one item; returns at the edge where it is taken.
  task automatic send_item(logic [31:0] e, logic l);
    if (!steady) begin
      while ($urandom_range(99) < 32) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= e;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    path_sb.note_input(e, l);
    items_sent++;
  endtask

  task automatic send_set(logic [31:0] vals [$]);
    foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
  endtask

  // Random set: mostly descending with varied magnitudes, sometimes a zero
  // tail, sometimes oversized, sometimes unsorted noise.
  task automatic send_random_set();
    logic [31:0] vals [$];
    int          n;
    int          pick;
    pick = $urandom_range(99);
    n = (pick < 10) ? $urandom_range(MAX_DIM + 1, MAX_DIM + 4)
                    : (pick < 25 ? $urandom_range(1, 3) : $urandom_range(2, 10));
    repeat (n) vals.insert(vals.size(), $urandom >> $urandom_range(31, 0));
    if ($urandom_range(99) < 85) vals.rsort();
    if ($urandom_range(99) < 20)
      for (int i = n - $urandom_range(1, n); i < n; i++) vals[i] = 32'd0;
    send_set(vals);
  endtask

  task automatic wait_drained();
    while (path_sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed sets: single items, extremes, ties, zeros, unsorted
    send_set('{32'h0001_0000});
    send_set('{32'h0000_0000});
    send_set('{32'hFFFF_FFFF});
    send_set('{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
    send_set('{32'hFFFF_FFFF, 32'h0000_0001});
    send_set('{32'h0003_0000, 32'h0002_0000, 32'h0001_0000});
    send_set('{32'h0004_0000, 32'h0000_0000, 32'h0000_0000});
    send_set('{32'h0000_0000, 32'h0000_0000});
    send_set('{32'h0000_0001, 32'h0005_0000, 32'h0002_0000});

    while (items_sent < 340) begin
      steady = (items_sent >= 150 && items_sent < 220);
      if (items_sent >= 250 && !drained_once) begin
        // hold the source until the whole path has drained
        drained_once = 1'b1;
        s_tvalid <= 1'b0;
        wait_drained();
        @(posedge clk);
      end
      send_random_set();
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    wait_drained();
    repeat (300) @(posedge clk);

    $display("Covered %0d eigenvalue items in %0d sets, %0d path points checked.",
             items_sent, path_sb.sets, path_sb.points);
    $display("Sets included extremes, zeros, ties, oversized and unsorted input.");
    if (path_sb.errors == 0 && path_sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (path_sb.expected_q.size() != 0)
        $display("%0d expected points never arrived", path_sb.expected_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #24_000_000;
    $display("Timeout with %0d points outstanding", path_sb.expected_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
